FILE: rtl/core/sdt_pkg.sv
package sdt_pkg;

    localparam int COORD_BITS   = 12;
    localparam int CORDIC_ITERS = 16;

    // The angle table has 24 entries, so longer runs are capped there.
    localparam int ANG_TABLE_LEN = 24;
    localparam int ITER_N = (CORDIC_ITERS > ANG_TABLE_LEN) ? ANG_TABLE_LEN : CORDIC_ITERS;
    localparam int ITER_W = $clog2(ITER_N);

    localparam int VEC_SCALE = 24;
    localparam int VEC_W     = COORD_BITS + VEC_SCALE + 4;
    localparam int Z_W       = 32;
    localparam int FINE_BITS = 16;
    localparam int A_W       = 30;
    localparam int FULL_W    = 33;

    localparam int DIR_W  = 16;
    localparam int TURN_W = 15;

    localparam int S_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DIR_W + TURN_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    localparam logic [DIR_W-1:0] DIR_QUARTER = DIR_W'(9000);
    localparam logic [DIR_W-1:0] DIR_HALF    = DIR_W'(18000);
    localparam logic [DIR_W-1:0] DIR_THREE_Q = DIR_W'(27000);
    localparam logic [DIR_W-1:0] DIR_FULL    = DIR_W'(36000);

    localparam logic signed [Z_W-1:0]  Z_MAX       = Z_W'(64'd9000 << FINE_BITS);
    localparam logic [FULL_W-1:0]      HALF_FINE   = FULL_W'(64'd18000 << FINE_BITS);
    localparam logic [FULL_W-1:0]      FULL_FINE   = FULL_W'(64'd36000 << FINE_BITS);

    // atan(2^-i) in units of 1/65536 centidegree, rounded to nearest.
    localparam logic signed [Z_W-1:0] ANG_STEP [0:ANG_TABLE_LEN-1] = '{
        32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
        32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
        32'sd1466765,   32'sd733385,    32'sd366693,   32'sd183347,
        32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
        32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
        32'sd358,       32'sd179,       32'sd90,       32'sd45
    };

    typedef struct packed {
        logic load;
        logic step;
        logic map;
        logic finish;
    } sdt_cmd_t;

    typedef struct packed {
        logic last_iter;
    } sdt_status_t;

endpackage

FILE: rtl/core/sdt_ctrl.sv
module sdt_ctrl
    import sdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        m_tready,
    output logic        m_tvalid,
    input  sdt_status_t status,
    output sdt_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ITER = 2'd1;
    localparam logic [1:0] ST_MAP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The output register frees up in the same cycle its request is taken.
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                cmd.step = 1'b1;
                if (status.last_iter)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                cmd.map    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

FILE: rtl/core/sdt_datapath.sv
module sdt_datapath
    import sdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [COORD_BITS-1:0] x_coord,
    input  logic [COORD_BITS-1:0] y_coord,
    input  logic                  stroke_start,
    input  sdt_cmd_t              cmd,
    output sdt_status_t           status,
    output logic [DIR_W-1:0]      direction,
    output logic                  direction_valid,
    output logic [TURN_W-1:0]     turn_amount,
    output logic                  turn_valid
);

    // History, cleared by reset.
    logic [COORD_BITS-1:0] prev_x_reg;
    logic [COORD_BITS-1:0] prev_y_reg;
    logic [DIR_W-1:0]      prev_dir_reg;
    logic                  have_point_reg;
    logic                  have_dir_reg;

    // Working registers of the request in flight.
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic                  start_reg;
    logic                  dx_neg_reg;
    logic                  dx_zero_reg;
    logic                  dy_neg_reg;
    logic                  dy_zero_reg;
    logic signed [VEC_W-1:0] cx_reg;
    logic signed [VEC_W-1:0] cy_reg;
    logic signed [Z_W-1:0]   cz_reg;
    logic [ITER_W-1:0]       iter_reg;
    logic [DIR_W-1:0]        dir_reg;

    // Output register.
    logic [DIR_W-1:0]  out_dir_reg;
    logic              out_dvalid_reg;
    logic [TURN_W-1:0] out_turn_reg;
    logic              out_tvalid_reg;

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic signed [COORD_BITS:0] adx;
    logic signed [COORD_BITS:0] ady;
    logic signed [VEC_W-1:0]    xs;
    logic signed [VEC_W-1:0]    ys;
    logic signed [Z_W-1:0]      ang;
    logic [A_W-1:0]             a_clamp;
    logic [FULL_W-1:0]          full;
    logic [FULL_W-FINE_BITS-1:0] d_wide;
    logic [DIR_W-1:0]           dir_cordic;
    logic [DIR_W-1:0]           dir_sel;
    logic                       hp;
    logic                       hd;
    logic [DIR_W-1:0]           diff;
    logic [DIR_W-1:0]           turn_wrap;

    assign hp = have_point_reg && !start_reg;
    assign hd = have_dir_reg && !start_reg;

    assign dx  = $signed({1'b0, x_coord}) - $signed({1'b0, prev_x_reg});
    assign dy  = $signed({1'b0, y_coord}) - $signed({1'b0, prev_y_reg});
    assign adx = dx[COORD_BITS] ? -dx : dx;
    assign ady = dy[COORD_BITS] ? -dy : dy;

    // Arithmetic shifts round toward minus infinity.
    assign xs  = cx_reg >>> iter_reg;
    assign ys  = cy_reg >>> iter_reg;
    assign ang = ANG_STEP[iter_reg];

    assign status.last_iter = (iter_reg == ITER_W'(ITER_N - 1));

    always_comb
    begin
        if (cz_reg < 0)
        begin
            a_clamp = '0;
        end
        else if (cz_reg > Z_MAX)
        begin
            a_clamp = A_W'(Z_MAX);
        end
        else
        begin
            a_clamp = A_W'(cz_reg);
        end

        if (!dx_neg_reg && !dy_neg_reg)
        begin
            full = FULL_W'(a_clamp);
        end
        else if (dx_neg_reg && !dy_neg_reg)
        begin
            full = HALF_FINE - FULL_W'(a_clamp);
        end
        else if (dx_neg_reg)
        begin
            full = HALF_FINE + FULL_W'(a_clamp);
        end
        else
        begin
            full = FULL_FINE - FULL_W'(a_clamp);
        end

        d_wide = full[FULL_W-1:FINE_BITS];
        if (d_wide >= (FULL_W - FINE_BITS)'(DIR_FULL))
        begin
            dir_cordic = '0;
        end
        else
        begin
            dir_cordic = DIR_W'(d_wide);
        end

        // Steps along an axis are exact; a zero step gives zero.
        if (!hp)
        begin
            dir_sel = '0;
        end
        else if (dy_zero_reg)
        begin
            dir_sel = dx_neg_reg ? DIR_HALF : '0;
        end
        else if (dx_zero_reg)
        begin
            dir_sel = dy_neg_reg ? DIR_THREE_Q : DIR_QUARTER;
        end
        else
        begin
            dir_sel = dir_cordic;
        end
    end

    always_comb
    begin
        diff = (dir_reg > prev_dir_reg) ? dir_reg - prev_dir_reg : prev_dir_reg - dir_reg;
        if (diff > DIR_HALF)
        begin
            turn_wrap = DIR_FULL - diff;
        end
        else
        begin
            turn_wrap = diff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg       <= x_coord;
            y_reg       <= y_coord;
            start_reg   <= stroke_start;
            dx_neg_reg  <= dx[COORD_BITS];
            dx_zero_reg <= (dx == '0);
            dy_neg_reg  <= dy[COORD_BITS];
            dy_zero_reg <= (dy == '0);
            cx_reg      <= $signed(VEC_W'(adx[COORD_BITS-1:0])) <<< VEC_SCALE;
            cy_reg      <= $signed(VEC_W'(ady[COORD_BITS-1:0])) <<< VEC_SCALE;
            cz_reg      <= '0;
            iter_reg    <= '0;
        end
        else if (cmd.step)
        begin
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + ang;
            end
            else
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - ang;
            end
            iter_reg <= iter_reg + 1'b1;
        end

        if (cmd.map)
        begin
            dir_reg <= dir_sel;
        end

        if (cmd.finish)
        begin
            out_dir_reg    <= dir_reg;
            out_dvalid_reg <= hp;
            out_turn_reg   <= (hp && hd) ? TURN_W'(turn_wrap) : '0;
            out_tvalid_reg <= hp && hd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_dir_reg   <= '0;
            have_point_reg <= 1'b0;
            have_dir_reg   <= 1'b0;
        end
        else if (cmd.finish)
        begin
            prev_x_reg     <= x_reg;
            prev_y_reg     <= y_reg;
            have_point_reg <= 1'b1;
            if (hp)
            begin
                prev_dir_reg <= dir_reg;
                have_dir_reg <= 1'b1;
            end
            else if (start_reg)
            begin
                have_dir_reg <= 1'b0;
            end
        end
    end

    assign direction       = out_dir_reg;
    assign direction_valid = out_dvalid_reg;
    assign turn_amount     = out_turn_reg;
    assign turn_valid      = out_tvalid_reg;

endmodule

FILE: rtl/core/stroke_direction_tracker.sv
// One point per request, and only one point at a time: s_tready is high only in the idle
// state, so the iterative CORDIC loop finishes a point before the next is taken.
// A result shows on m_tvalid in the same cycle that s_tready returns, so the next point
// runs while the result waits; it is held at the end until the output register is free.
// rst_n is asynchronous and active low; it clears the controller, the output
// valid and the stroke history.
module stroke_direction_tracker
    import sdt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // x_coord, y_coord, zero fill
    input  logic                 s_tuser,  // stroke_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // direction, turn_amount, zero fill
    output logic [M_TUSER_W-1:0] m_tuser   // direction_valid, turn_valid
);

    sdt_cmd_t          cmd;
    sdt_status_t       status;
    logic [DIR_W-1:0]  direction;
    logic              direction_valid;
    logic [TURN_W-1:0] turn_amount;
    logic              turn_valid;

    sdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    sdt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .x_coord         (s_tdata[COORD_BITS-1:0]),
        .y_coord         (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .stroke_start    (s_tuser),
        .cmd             (cmd),
        .status          (status),
        .direction       (direction),
        .direction_valid (direction_valid),
        .turn_amount     (turn_amount),
        .turn_valid      (turn_valid)
    );

    assign m_tdata = M_TDATA_W'({turn_amount, direction});
    assign m_tuser = {turn_valid, direction_valid};

endmodule

FILE: rtl/core/sdt_checker.sv
module sdt_checker
    import sdt_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // One point at a time: the block is busy right after taking a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // A turn needs a direction.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("turn valid without direction valid");

    // Invalid fields read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("invalid result is not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[DIR_W-1:0] < DIR_FULL)
            && (m_tdata[DIR_W+TURN_W-1:DIR_W] <= TURN_W'(DIR_HALF)))
        else $error("result out of range");

endmodule

bind stroke_direction_tracker sdt_checker u_sdt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
